@@ src/vsam_pkg.sv @@
// ----------------------------------------------------------------------------
// vsam_pkg
// Shared types, constants and helpers for the vital sign alarm monitor.
// ----------------------------------------------------------------------------
package vsam_pkg;

  // Window length default and queue depth between front and back
  localparam int WINDOW_DEPTH_DEFAULT = 8;
  localparam int FIFO_DEPTH           = 2;

  // Sample field widths
  localparam int HR_W   = 15;
  localparam int TEMP_W = 13;
  localparam int BP_W   = 15;

  // Divider: quotient bits produced, bits retired per cycle
  localparam int QUO_W      = 16;
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = QUO_W / DIV_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;
  localparam int CNT_REQ_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HR_WARN_LOW    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HR_WARN_HIGH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BP_WARN_LOW    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BP_WARN_HIGH   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_REQUIRED  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EMERG_REQUIRED = 4'd7;

  // Fixed critical bands, hundredths
  localparam logic [HR_W-1:0] HR_CRIT_LOW    = 15'd4000;
  localparam logic [HR_W-1:0] HR_CRIT_MAX    = 15'd14000;
  localparam logic [HR_W-1:0] TEMP_CRIT_LOW  = 15'd3400;
  localparam logic [HR_W-1:0] TEMP_CRIT_HIGH = 15'd4000;
  localparam logic [HR_W-1:0] BP_CRIT_LOW    = 15'd6000;
  localparam logic [HR_W-1:0] BP_CRIT_HIGH   = 15'd18000;

  localparam logic [CNT_REQ_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    ALERT_NORMAL    = 2'd0,
    ALERT_WARNING   = 2'd1,
    ALERT_EMERGENCY = 2'd2
  } alert_e;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_EVAL
  } back_state_e;

  typedef struct packed {
    logic [HR_W-1:0]      hr_warn_low;
    logic [HR_W-1:0]      hr_warn_high;
    logic [TEMP_W-1:0]    temp_warn_low;
    logic [TEMP_W-1:0]    temp_warn_high;
    logic [BP_W-1:0]      bp_warn_low;
    logic [BP_W-1:0]      bp_warn_high;
    logic [CNT_REQ_W-1:0] warn_required;
    logic [CNT_REQ_W-1:0] emerg_required;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    hr_warn_low:    15'd6000,
    hr_warn_high:   15'd10000,
    temp_warn_low:  13'd3610,
    temp_warn_high: 13'd3720,
    bp_warn_low:    15'd9000,
    bp_warn_high:   15'd12000,
    warn_required:  4'd3,
    emerg_required: 4'd2
  };

  // Mean q = floor(sum/n), rem_nz = remainder nonzero.
  // sum/n > hi  <=>  q > hi, or q == hi with a nonzero remainder.
  function automatic logic outside_band(input logic [HR_W-1:0] q, input logic rem_nz,
                                        input logic [HR_W-1:0] lo,
                                        input logic [HR_W-1:0] hi);
    return (q < lo) || (q > hi) || ((q == hi) && rem_nz);
  endfunction

  function automatic alert_e classify(input logic [HR_W-1:0] q, input logic rem_nz,
                                      input logic [HR_W-1:0] crit_lo,
                                      input logic [HR_W-1:0] crit_hi,
                                      input logic [HR_W-1:0] warn_lo,
                                      input logic [HR_W-1:0] warn_hi);
    alert_e sev;
    if (outside_band(q, rem_nz, crit_lo, crit_hi)) begin
      sev = ALERT_EMERGENCY;
    end else if (outside_band(q, rem_nz, warn_lo, warn_hi)) begin
      sev = ALERT_WARNING;
    end else begin
      sev = ALERT_NORMAL;
    end
    return sev;
  endfunction

endpackage

@@ src/vsam_ram.sv @@
// ----------------------------------------------------------------------------
// vsam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/vsam_front.sv @@
// ----------------------------------------------------------------------------
// vsam_front
// Accepts samples, keeps the sample windows and running sums, queues sums.
// ----------------------------------------------------------------------------
module vsam_front #(
  parameter int WINDOW_DEPTH = vsam_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [vsam_pkg::HR_W-1:0]   hr_i,
  input  logic [vsam_pkg::TEMP_W-1:0] temp_i,
  input  logic [vsam_pkg::BP_W-1:0]   bp_i,
  output logic                       push_o,
  output logic [15+$clog2(WINDOW_DEPTH)+13+$clog2(WINDOW_DEPTH)+15+$clog2(WINDOW_DEPTH)
                +$clog2(WINDOW_DEPTH+1)-1:0] push_data_o,
  input  logic                       full_i
);

  localparam int IDX_W   = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int HRS_W   = vsam_pkg::HR_W + IDX_W;
  localparam int TPS_W   = vsam_pkg::TEMP_W + IDX_W;
  localparam int BPS_W   = vsam_pkg::BP_W + IDX_W;
  localparam int SMP_W   = vsam_pkg::HR_W + vsam_pkg::TEMP_W + vsam_pkg::BP_W;

  vsam_pkg::front_state_e state_q, state_d;

  logic [vsam_pkg::HR_W-1:0]   hr_q;
  logic [vsam_pkg::TEMP_W-1:0] temp_q;
  logic [vsam_pkg::BP_W-1:0]   bp_q;
  logic [HRS_W-1:0] hr_sum_q, hr_sum_d;
  logic [TPS_W-1:0] temp_sum_q, temp_sum_d;
  logic [BPS_W-1:0] bp_sum_q, bp_sum_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic             full_q, full_d;

  logic             accept;
  logic             commit;
  logic             wrap;
  logic [CNT_W-1:0] count;
  logic [SMP_W-1:0] ram_rdata;
  logic [SMP_W-1:0] old_smp;

  assign ready_o = (state_q == vsam_pkg::FRONT_IDLE);
  assign accept  = valid_i && ready_o;
  assign commit  = (state_q == vsam_pkg::FRONT_UPDATE) && !full_i;

  // One row holds all three samples of one slot: {bp, temp, hr}
  vsam_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (wr_idx_q),
    .wdata_i ({bp_q, temp_q, hr_q}),
    .re_i    (accept),
    .raddr_i (wr_idx_q),
    .rdata_o (ram_rdata)
  );

  // Slots not yet written since reset count as zero
  assign old_smp = full_q ? ram_rdata : '0;

  assign wrap = (wr_idx_q == IDX_W'(WINDOW_DEPTH - 1));

  always_comb begin
    state_d    = state_q;
    hr_sum_d   = hr_sum_q;
    temp_sum_d = temp_sum_q;
    bp_sum_d   = bp_sum_q;
    wr_idx_d   = wr_idx_q;
    full_d     = full_q;
    push_o     = 1'b0;
    count      = (full_q || wrap) ? CNT_W'(WINDOW_DEPTH) : (CNT_W'(wr_idx_q) + 1'b1);

    hr_sum_d   = hr_sum_q - HRS_W'(old_smp[vsam_pkg::HR_W-1:0]) + HRS_W'(hr_q);
    temp_sum_d = temp_sum_q
               - TPS_W'(old_smp[vsam_pkg::HR_W +: vsam_pkg::TEMP_W]) + TPS_W'(temp_q);
    bp_sum_d   = bp_sum_q
               - BPS_W'(old_smp[vsam_pkg::HR_W + vsam_pkg::TEMP_W +: vsam_pkg::BP_W])
               + BPS_W'(bp_q);

    case (state_q)
      vsam_pkg::FRONT_IDLE: begin
        if (accept) begin
          state_d = vsam_pkg::FRONT_UPDATE;
        end
        hr_sum_d   = hr_sum_q;
        temp_sum_d = temp_sum_q;
        bp_sum_d   = bp_sum_q;
      end
      vsam_pkg::FRONT_UPDATE: begin
        if (commit) begin
          push_o   = 1'b1;
          wr_idx_d = wrap ? '0 : wr_idx_q + 1'b1;
          full_d   = full_q || wrap;
          state_d  = vsam_pkg::FRONT_IDLE;
        end else begin
          hr_sum_d   = hr_sum_q;
          temp_sum_d = temp_sum_q;
          bp_sum_d   = bp_sum_q;
        end
      end
      default: begin
        state_d = vsam_pkg::FRONT_IDLE;
      end
    endcase
  end

  assign push_data_o = {count, bp_sum_d, temp_sum_d, hr_sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vsam_pkg::FRONT_IDLE;
      hr_sum_q   <= '0;
      temp_sum_q <= '0;
      bp_sum_q   <= '0;
      wr_idx_q   <= '0;
      full_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      hr_sum_q   <= hr_sum_d;
      temp_sum_q <= temp_sum_d;
      bp_sum_q   <= bp_sum_d;
      wr_idx_q   <= wr_idx_d;
      full_q     <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hr_q   <= hr_i;
      temp_q <= temp_i;
      bp_q   <= bp_i;
    end
  end

endmodule

@@ src/vsam_fifo.sv @@
// ----------------------------------------------------------------------------
// vsam_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module vsam_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = vsam_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/vsam_back.sv @@
// ----------------------------------------------------------------------------
// vsam_back
// Divides the sums, tests the bands, debounces and holds the result.
// ----------------------------------------------------------------------------
module vsam_back #(
  parameter int WINDOW_DEPTH = vsam_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [15+$clog2(WINDOW_DEPTH)+13+$clog2(WINDOW_DEPTH)+15+$clog2(WINDOW_DEPTH)
                +$clog2(WINDOW_DEPTH+1)-1:0] pop_data_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  vsam_pkg::cfg_regs_t         cfg_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [1:0]                 alert_state_o,
  output logic                       state_changed_o,
  output logic [vsam_pkg::HR_W-1:0]   hr_average_o,
  output logic [vsam_pkg::TEMP_W-1:0] temp_average_o,
  output logic [vsam_pkg::BP_W-1:0]   bp_average_o
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int HRS_W  = vsam_pkg::HR_W + IDX_W;
  localparam int TPS_W  = vsam_pkg::TEMP_W + IDX_W;
  localparam int BPS_W  = vsam_pkg::BP_W + IDX_W;
  localparam int QUO_W  = vsam_pkg::QUO_W;
  localparam int D_W    = CNT_W + QUO_W;
  localparam int IT_W   = (vsam_pkg::DIV_CYCLES > 1) ? $clog2(vsam_pkg::DIV_CYCLES) : 1;
  localparam int LANES  = 3;
  localparam int L_HR   = 0;
  localparam int L_TEMP = 1;
  localparam int L_BP   = 2;
  localparam int Q_W    = vsam_pkg::HR_W;

  // Several restoring steps per cycle; divisor shifts right by one per step
  function automatic logic [QUO_W+D_W-1:0] div_steps(input logic [D_W-1:0]   rem,
                                                    input logic [QUO_W-1:0] quo,
                                                    input logic [D_W-1:0]   dsr);
    logic [D_W-1:0]   r;
    logic [QUO_W-1:0] q;
    logic [D_W-1:0]   d;
    r = rem;
    q = quo;
    d = dsr;
    for (int j = 0; j < vsam_pkg::DIV_BITS; j++) begin
      if (r >= d) begin
        r = r - d;
        q = {q[QUO_W-2:0], 1'b1};
      end else begin
        q = {q[QUO_W-2:0], 1'b0};
      end
      d = d >> 1;
    end
    return {q, r};
  endfunction

  vsam_pkg::back_state_e state_q, state_d;

  logic [IT_W-1:0]  iter_q, iter_d;
  logic [D_W-1:0]   rem_q [LANES];
  logic [D_W-1:0]   rem_d [LANES];
  logic [QUO_W-1:0] quo_q [LANES];
  logic [QUO_W-1:0] quo_d [LANES];
  logic [D_W-1:0]   dsr_q, dsr_d;

  logic [vsam_pkg::CNT_REQ_W-1:0] warn_cnt_q, warn_cnt_d;
  logic [vsam_pkg::CNT_REQ_W-1:0] emerg_cnt_q, emerg_cnt_d;
  vsam_pkg::alert_e               alert_q, alert_d;
  logic                           out_valid_q, out_valid_d;

  logic [1:0]                 out_alert_q;
  logic                       out_changed_q;
  logic [vsam_pkg::HR_W-1:0]   out_hr_q;
  logic [vsam_pkg::TEMP_W-1:0] out_temp_q;
  logic [vsam_pkg::BP_W-1:0]   out_bp_q;

  logic [HRS_W-1:0] in_hr_sum;
  logic [TPS_W-1:0] in_temp_sum;
  logic [BPS_W-1:0] in_bp_sum;
  logic [CNT_W-1:0] in_count;
  logic [D_W-1:0]   load_rem [LANES];

  logic                 load;
  logic                 emit;
  logic                 out_free;
  logic [LANES-1:0]     rem_nz;
  vsam_pkg::alert_e     sev_hr, sev_temp, sev_bp;
  logic                 emerg_seen, warn_seen;
  logic [QUO_W+D_W-1:0] step_res [LANES];

  assign {in_count, in_bp_sum, in_temp_sum, in_hr_sum} = pop_data_i;
  assign load_rem[L_HR]   = D_W'(in_hr_sum);
  assign load_rem[L_TEMP] = D_W'(in_temp_sum);
  assign load_rem[L_BP]   = D_W'(in_bp_sum);

  assign out_free = !out_valid_q || ready_i;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      step_res[l] = div_steps(rem_q[l], quo_q[l], dsr_q);
      rem_nz[l]   = (rem_q[l] != '0);
    end
  end

  // Band tests on the finished quotients
  always_comb begin
    sev_hr   = vsam_pkg::classify(quo_q[L_HR][Q_W-1:0], rem_nz[L_HR],
                                 vsam_pkg::HR_CRIT_LOW, vsam_pkg::HR_CRIT_MAX,
                                 cfg_i.hr_warn_low, cfg_i.hr_warn_high);
    sev_temp = vsam_pkg::classify(quo_q[L_TEMP][Q_W-1:0], rem_nz[L_TEMP],
                                 vsam_pkg::TEMP_CRIT_LOW, vsam_pkg::TEMP_CRIT_HIGH,
                                 Q_W'(cfg_i.temp_warn_low), Q_W'(cfg_i.temp_warn_high));
    sev_bp   = vsam_pkg::classify(quo_q[L_BP][Q_W-1:0], rem_nz[L_BP],
                                 vsam_pkg::BP_CRIT_LOW, vsam_pkg::BP_CRIT_HIGH,
                                 cfg_i.bp_warn_low, cfg_i.bp_warn_high);
    emerg_seen = (sev_hr == vsam_pkg::ALERT_EMERGENCY) ||
                 (sev_temp == vsam_pkg::ALERT_EMERGENCY) ||
                 (sev_bp == vsam_pkg::ALERT_EMERGENCY);
    warn_seen  = (sev_hr == vsam_pkg::ALERT_WARNING) ||
                 (sev_temp == vsam_pkg::ALERT_WARNING) ||
                 (sev_bp == vsam_pkg::ALERT_WARNING);
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    dsr_d       = dsr_q;
    warn_cnt_d  = warn_cnt_q;
    emerg_cnt_d = emerg_cnt_q;
    alert_d     = alert_q;
    out_valid_d = out_valid_q && !ready_i;
    load        = 1'b0;
    emit        = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
    end

    case (state_q)
      vsam_pkg::BACK_IDLE: begin
        load = !empty_i;
      end
      vsam_pkg::BACK_DIV: begin
        for (int l = 0; l < LANES; l++) begin
          quo_d[l] = step_res[l][D_W +: QUO_W];
          rem_d[l] = step_res[l][D_W-1:0];
        end
        dsr_d  = dsr_q >> vsam_pkg::DIV_BITS;
        iter_d = iter_q + 1'b1;
        if (iter_q == IT_W'(vsam_pkg::DIV_CYCLES - 1)) begin
          state_d = vsam_pkg::BACK_EVAL;
        end
      end
      vsam_pkg::BACK_EVAL: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = vsam_pkg::BACK_IDLE;
          load = !empty_i;
        end
      end
      default: begin
        state_d = vsam_pkg::BACK_IDLE;
      end
    endcase

    if (emit) begin
      if (emerg_seen) begin
        emerg_cnt_d = (emerg_cnt_q == vsam_pkg::COUNT_MAX) ? emerg_cnt_q : emerg_cnt_q + 1'b1;
        warn_cnt_d  = '0;
      end else if (warn_seen) begin
        warn_cnt_d  = (warn_cnt_q == vsam_pkg::COUNT_MAX) ? warn_cnt_q : warn_cnt_q + 1'b1;
        emerg_cnt_d = '0;
      end else begin
        warn_cnt_d  = '0;
        emerg_cnt_d = '0;
      end
      if (emerg_cnt_d >= cfg_i.emerg_required) begin
        alert_d = vsam_pkg::ALERT_EMERGENCY;
      end else if (warn_cnt_d >= cfg_i.warn_required) begin
        alert_d = vsam_pkg::ALERT_WARNING;
      end else begin
        alert_d = vsam_pkg::ALERT_NORMAL;
      end
      out_valid_d = 1'b1;
    end

    if (load) begin
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = load_rem[l];
        quo_d[l] = '0;
      end
      dsr_d   = D_W'(in_count) << (QUO_W - 1);
      iter_d  = '0;
      state_d = vsam_pkg::BACK_DIV;
    end
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsam_pkg::BACK_IDLE;
      iter_q      <= '0;
      warn_cnt_q  <= '0;
      emerg_cnt_q <= '0;
      alert_q     <= vsam_pkg::ALERT_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      warn_cnt_q  <= warn_cnt_d;
      emerg_cnt_q <= emerg_cnt_d;
      alert_q     <= alert_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    for (int l = 0; l < LANES; l++) begin
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
    end
    if (emit) begin
      out_alert_q   <= alert_d;
      out_changed_q <= (alert_d != alert_q);
      out_hr_q      <= quo_q[L_HR][vsam_pkg::HR_W-1:0];
      out_temp_q    <= quo_q[L_TEMP][vsam_pkg::TEMP_W-1:0];
      out_bp_q      <= quo_q[L_BP][vsam_pkg::BP_W-1:0];
    end
  end

  assign valid_o         = out_valid_q;
  assign alert_state_o   = out_alert_q;
  assign state_changed_o = out_changed_q;
  assign hr_average_o    = out_hr_q;
  assign temp_average_o  = out_temp_q;
  assign bp_average_o    = out_bp_q;

endmodule

@@ src/vital_sign_alarm_monitor.sv @@
// ----------------------------------------------------------------------------
// vital_sign_alarm_monitor
// Windowed-mean alarm over heart rate, temperature and blood pressure.
// ----------------------------------------------------------------------------
// Flow: the front accepts an item, updates window and sums and queues them;
//   the back end's divider (4 quotient bits per cycle) forms the means, then an
//   evaluate step emits the result. Neither takes an item before the last is done.
// Reset: async, active low; clears sums, window index, counters and alert,
//   loads the threshold registers with their defaults. Window memory is not
//   cleared: slots are masked as zero until the window first fills.
module vital_sign_alarm_monitor #(
  parameter int WINDOW_DEPTH = vsam_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [14:0] heart_rate, [27:15] temperature, [42:28] blood_pressure, [47:43] zero
  input  logic [47:0]                    s_axis_tdata,
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] alert_state, [2] state_changed, [17:3] hr_average,
  // [30:18] temp_average, [45:31] bp_average, [47:46] zero
  output logic [47:0]                    m_axis_tdata,
  // Register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vsam_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vsam_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ITEM_W = vsam_pkg::HR_W + vsam_pkg::TEMP_W + vsam_pkg::BP_W
                        + 3 * IDX_W + CNT_W;

  // --------------------------------------------------------------------------
  // Threshold and debounce registers
  // --------------------------------------------------------------------------
  vsam_pkg::cfg_regs_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vsam_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vsam_pkg::REG_HR_WARN_LOW:    cfg_q.hr_warn_low    <= cfg_data_i[vsam_pkg::HR_W-1:0];
        vsam_pkg::REG_HR_WARN_HIGH:   cfg_q.hr_warn_high   <= cfg_data_i[vsam_pkg::HR_W-1:0];
        vsam_pkg::REG_TEMP_WARN_LOW:  cfg_q.temp_warn_low  <= cfg_data_i[vsam_pkg::TEMP_W-1:0];
        vsam_pkg::REG_TEMP_WARN_HIGH: cfg_q.temp_warn_high <= cfg_data_i[vsam_pkg::TEMP_W-1:0];
        vsam_pkg::REG_BP_WARN_LOW:    cfg_q.bp_warn_low    <= cfg_data_i[vsam_pkg::BP_W-1:0];
        vsam_pkg::REG_BP_WARN_HIGH:   cfg_q.bp_warn_high   <= cfg_data_i[vsam_pkg::BP_W-1:0];
        vsam_pkg::REG_WARN_REQUIRED:
          cfg_q.warn_required  <= cfg_data_i[vsam_pkg::CNT_REQ_W-1:0];
        vsam_pkg::REG_EMERG_REQUIRED:
          cfg_q.emerg_required <= cfg_data_i[vsam_pkg::CNT_REQ_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front: window memory and running sums
  // --------------------------------------------------------------------------
  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              fifo_full;
  logic              fifo_empty;
  logic              pop;
  logic [ITEM_W-1:0] pop_data;

  vsam_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .hr_i        (s_axis_tdata[14:0]),
    .temp_i      (s_axis_tdata[27:15]),
    .bp_i        (s_axis_tdata[42:28]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (fifo_full)
  );

  // Sums and sample count, waiting for the divider
  vsam_fifo #(
    .DATA_W (ITEM_W),
    .DEPTH  (vsam_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // --------------------------------------------------------------------------
  // Back: means, band tests, debounce, result register
  // --------------------------------------------------------------------------
  logic [1:0]                 alert_state;
  logic                       state_changed;
  logic [vsam_pkg::HR_W-1:0]   hr_average;
  logic [vsam_pkg::TEMP_W-1:0] temp_average;
  logic [vsam_pkg::BP_W-1:0]   bp_average;

  vsam_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_data_i      (pop_data),
    .empty_i         (fifo_empty),
    .pop_o           (pop),
    .cfg_i           (cfg_q),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .alert_state_o   (alert_state),
    .state_changed_o (state_changed),
    .hr_average_o    (hr_average),
    .temp_average_o  (temp_average),
    .bp_average_o    (bp_average)
  );

  assign m_axis_tdata = {2'b00, bp_average, temp_average, hr_average,
                         state_changed, alert_state};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_full))
    else $error("queue written while full");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_empty))
    else $error("queue popped while empty");

  // Front does not accept items back to back: it updates after each accepted item
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("front accepted items back to back");

  // Result alert code is always a defined level
  a_alert_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b11))
    else $error("undefined alert code on result");

endmodule
